// ===== src/upd_pkg.sv =====
// upd_pkg: shared types, constants and hex helpers for the url percent decoder
// used by upd_front, upd_cmd_fifo, upd_back and url_percent_decoder
package upd_pkg;

  localparam logic [7:0] PctChar  = 8'h25;
  localparam logic [7:0] Dig0Char = 8'h30;
  localparam logic [7:0] Dig9Char = 8'h39;
  localparam logic [7:0] UpAChar  = 8'h41;
  localparam logic [7:0] UpFChar  = 8'h46;
  localparam logic [7:0] LoAChar  = 8'h61;
  localparam logic [7:0] LoFChar  = 8'h66;
  localparam logic [3:0] HexTen   = 4'd10;

  localparam int unsigned MaxBytes  = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  // one decoded step: up to three output words, last flag for the final one
  typedef struct packed {
    logic [1:0]                cnt;
    logic [MaxBytes-1:0][7:0]  bytes;
    logic                      last;
  } cmd_t;

  function automatic logic hex_ok(input logic [7:0] c);
    return ((c >= Dig0Char) && (c <= Dig9Char)) ||
           ((c >= UpAChar) && (c <= UpFChar)) ||
           ((c >= LoAChar) && (c <= LoFChar));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - Dig0Char;
    if ((c >= Dig0Char) && (c <= Dig9Char)) begin
      return d[3:0];
    end
    if ((c >= LoAChar) && (c <= LoFChar)) begin
      d = c - LoAChar;
      return d[3:0] + HexTen;
    end
    d = c - UpAChar;
    return d[3:0] + HexTen;
  endfunction

endpackage

// ===== src/upd_front.sv =====
// upd_front: escape tracker, turns each input word into a command of 0..3 words
// depends on upd_pkg
module upd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             cmd_push_o,
  output upd_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  logic          is_hex;
  logic          pass_byte;
  logic [1:0]    base_cnt;
  logic          do_idle;
  upd_pkg::cmd_t cmd;

  always_comb begin
    is_hex    = upd_pkg::hex_ok(in_byte_i);
    pass_byte = !((in_byte_i == upd_pkg::PctChar) && !in_last_i);
    phase_d   = phase_q;
    held_d    = held_q;
    base_cnt  = 2'd0;
    do_idle   = 1'b0;
    cmd.cnt   = 2'd0;
    cmd.bytes = '0;
    cmd.last  = in_last_i;
    case (phase_q)
      PhPct: begin
        if (is_hex) begin
          if (in_last_i) begin
            cmd.bytes[0] = upd_pkg::PctChar;
            cmd.bytes[1] = in_byte_i;
            cmd.cnt      = 2'd2;
            phase_d      = PhIdle;
          end else begin
            held_d  = in_byte_i;
            phase_d = PhDigit;
          end
        end else begin
          cmd.bytes[0] = upd_pkg::PctChar;
          base_cnt     = 2'd1;
          do_idle      = 1'b1;
        end
      end
      PhDigit: begin
        if (is_hex) begin
          cmd.bytes[0] = {upd_pkg::hex_val(held_q), upd_pkg::hex_val(in_byte_i)};
          cmd.cnt      = 2'd1;
          phase_d      = PhIdle;
        end else begin
          cmd.bytes[0] = upd_pkg::PctChar;
          cmd.bytes[1] = held_q;
          base_cnt     = 2'd2;
          do_idle      = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase
    if (do_idle) begin
      if (pass_byte) begin
        cmd.bytes[base_cnt] = in_byte_i;
        cmd.cnt             = base_cnt + 2'd1;
        phase_d             = PhIdle;
      end else begin
        cmd.cnt = base_cnt;
        phase_d = PhPct;
      end
    end
  end

  assign cmd_push_o = accept_i && (cmd.cnt != 2'd0);
  assign cmd_o      = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== src/upd_cmd_fifo.sv =====
// upd_cmd_fifo: short command queue between front and back
// depends on upd_pkg
module upd_cmd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  upd_pkg::cmd_t    push_cmd_i,
  output logic             full_o,
  input  logic             pop_i,
  output upd_pkg::cmd_t    head_cmd_o,
  output logic             empty_o
);

  upd_pkg::cmd_t                 mem_q [upd_pkg::FifoDepth];
  logic [upd_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [upd_pkg::FifoPtrW:0]    count_q;
  logic                          do_wr, do_rd;

  assign full_o     = (count_q == (upd_pkg::FifoPtrW + 1)'(upd_pkg::FifoDepth));
  assign empty_o    = (count_q == '0);
  assign do_wr      = push_i && !full_o;
  assign do_rd      = pop_i && !empty_o;
  assign head_cmd_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== src/upd_back.sv =====
// upd_back: walks each command word by word into the output register
// depends on upd_pkg
module upd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_empty_i,
  input  upd_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       final_word;

  assign load        = !cmd_empty_i && (!out_valid_q || pop_i);
  assign final_word  = (idx_q == (cmd_i.cnt - 2'd1));
  assign cmd_pop_o   = load && final_word;
  assign idx_d       = final_word ? 2'd0 : idx_q + 2'd1;
  assign out_valid_d = load || (out_valid_q && !pop_i);

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= cmd_i.bytes[idx_q];
      out_last_q <= cmd_i.last && final_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (load) begin
        idx_q <= idx_d;
      end
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

// ===== src/url_percent_decoder.sv =====
// url_percent_decoder: top level of the streaming percent decoder
// depends on upd_pkg, upd_front, upd_cmd_fifo and upd_back
//
// input side is a queue: a word (in_byte_i, in_last_i) is taken at a clock edge
// with push high and full low. result side is a queue too: while empty is
// low the oldest decoded word sits on out_byte_o/out_last_o and is taken at an
// edge with pop high.
// a '%' and two hex digits become one word; a broken escape passes through and
// the breaking word is scanned again; at end of string pending words are flushed
// and out_last_o marks the final one.
// the first result of a word goes into the command queue and is then loaded
// into the output register. throughput: one input word per cycle while full is
// low and one result per cycle while pop is high; the back end sends one result
// per cycle, so once the four-entry command queue fills, an input word giving
// two or three results holds the front until the queue has room again.
// reset clears the escape state, the command queue and the output register.
// if pop stays low the output register holds its word, the command queue
// fills and full rises; nothing is dropped.
module url_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic          accept;
  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_empty;
  logic          cmd_pop;
  upd_pkg::cmd_t cmd_wr;
  upd_pkg::cmd_t cmd_rd;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  upd_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (cmd_wr),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .head_cmd_o (cmd_rd),
    .empty_o    (cmd_empty)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  // front only writes a command when the queue has room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_push && cmd_full))
    else $error("command written into a full queue");

  // back only retires a command that is there
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command retired from an empty queue");

  // a queued command always carries at least one word
  a_cmd_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (cmd_wr.cnt != 2'd0))
    else $error("empty command queued");

  // a retired command makes the output register valid
  a_pop_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |=> !empty)
    else $error("retired command gave no output word");

endmodule

// ===== dv/tb_url_percent_decoder.sv =====
// tb_url_percent_decoder: self-checking testbench for the streaming url percent decoder
// drives directed and random byte strings through the queue ports against a scoreboard
// depends on upd_pkg and url_percent_decoder
module tb_url_percent_decoder;

  localparam int unsigned RandomWords = 450;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned HoldOffLen  = 300;

  typedef enum logic [1:0] {
    EscIdle  = 2'd0,
    EscPct   = 2'd1,
    EscDigit = 2'd2
  } esc_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_word_t;

  class decode_scoreboard;
    esc_phase_e  phase;
    logic [7:0]  held;
    dec_word_t   pending[$];
    int unsigned errors;

    function new();
      phase  = EscIdle;
      held   = '0;
      errors = 0;
    endfunction

    function bit is_hex(logic [7:0] c);
      return c inside {[upd_pkg::Dig0Char:upd_pkg::Dig9Char],
                       [upd_pkg::UpAChar:upd_pkg::UpFChar],
                       [upd_pkg::LoAChar:upd_pkg::LoFChar]};
    endfunction

    function logic [3:0] nibble(logic [7:0] c);
      if (c <= upd_pkg::Dig9Char) begin
        return c[3:0];
      end
      return c[3:0] + 4'd9;
    endfunction

    function void emit(logic [7:0] b, logic last);
      dec_word_t w;
      w.data = b;
      w.last = last;
      pending.push_back(w);
    endfunction

    function void plain_word(logic [7:0] b, logic last);
      if (b == upd_pkg::PctChar && !last) begin
        phase = EscPct;
      end else begin
        phase = EscIdle;
        emit(b, last);
      end
    endfunction

    function void note_raw_word(logic [7:0] b, logic last);
      case (phase)
        EscPct: begin
          if (is_hex(b)) begin
            if (last) begin
              emit(upd_pkg::PctChar, 1'b0);
              emit(b, 1'b1);
              phase = EscIdle;
            end else begin
              held  = b;
              phase = EscDigit;
            end
          end else begin
            emit(upd_pkg::PctChar, 1'b0);
            plain_word(b, last);
          end
        end
        EscDigit: begin
          if (is_hex(b)) begin
            emit({nibble(held), nibble(b)}, last);
            phase = EscIdle;
          end else begin
            emit(upd_pkg::PctChar, 1'b0);
            emit(held, 1'b0);
            plain_word(b, last);
          end
        end
        default: plain_word(b, last);
      endcase
    endfunction

    function void check_decoded_word(logic [7:0] b, logic last);
      dec_word_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word expected none got %02h last %0b", $time, b, last);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (b !== w.data) begin
        $display("%0t: out_byte expected %02h got %02h", $time, w.data, b);
        errors++;
      end
      if (last !== w.last) begin
        $display("%0t: out_last expected %0b got %0b", $time, w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       push      = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       pop       = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  decode_scoreboard sb = new();
  int unsigned burst_left = 0;

  url_percent_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .empty      (empty),
    .pop        (pop),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  task automatic send_word(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push      <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do @(posedge clk_i); while (full);
    sb.note_raw_word(b, last);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], i == s.len() - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned words_sent;
    int unsigned len;
    int unsigned pick;
    logic [3:0]  digit;
    logic [7:0]  c;
    words_sent = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("%41");
    send_text("%fF");
    send_text("%4G");
    send_text("%g%");
    send_text("%%9a");
    send_text("%4%");
    send_text("%4");
    send_text("%/`G");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);

    while (words_sent < RandomWords) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          c = upd_pkg::PctChar;
        end else if (pick < 7) begin
          digit = 4'($urandom_range(0, 15));
          if (digit < upd_pkg::HexTen) begin
            c = upd_pkg::Dig0Char + digit;
          end else begin
            c = ($urandom_range(0, 1) ? upd_pkg::UpAChar : upd_pkg::LoAChar) +
                (digit - upd_pkg::HexTen);
          end
        end else begin
          c = 8'($urandom_range(0, 255));
        end
        send_word(c, i == len - 1);
        words_sent++;
      end
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_url_percent_decoder OK");
    end else begin
      $display("tb_url_percent_decoder NOT OK");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned words_taken;
    int unsigned hold_left;
    int unsigned stretch_left;
    int unsigned mode;
    bit          held_off;
    words_taken  = 0;
    hold_left    = 0;
    stretch_left = 0;
    mode         = 0;
    held_off     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        sb.check_decoded_word(out_byte_o, out_last_o);
        words_taken++;
      end
      // long hold-off so the decoder fills up and backs off its input
      if (!held_off && words_taken == 60) begin
        held_off  = 1'b1;
        hold_left = HoldOffLen;
      end
      if (stretch_left == 0) begin
        mode         = $urandom_range(0, 3);
        stretch_left = $urandom_range(4, 40);
      end
      stretch_left--;
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'($urandom_range(0, 1));
          2: pop <= (stretch_left % 4 == 0);
          default: pop <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_url_percent_decoder NOT OK");
    $finish;
  end

endmodule
